[rtl/grid_frame_difference_detector_core_assert.svh]
// Assertion macros for the grid frame difference detector core.
`ifndef GRID_FRAME_DIFFERENCE_DETECTOR_CORE_ASSERT_SVH
`define GRID_FRAME_DIFFERENCE_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GFDD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GFDD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/gfdd_pkg.sv]
// Shared types, constants and register codes for the grid frame difference detector.
package gfdd_pkg;

	localparam int GRID_W_DEF = 16;
	localparam int GRID_H_DEF = 12;

	localparam int PIXEL_W    = 8;
	localparam int COORD_W    = 10;
	localparam int STEP_W     = 7;
	localparam int SUM_W      = 16;
	localparam int THRESH_W   = 16;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam logic [STEP_W-1:0]   STEP_X_RST    = STEP_W'(10);
	localparam logic [STEP_W-1:0]   STEP_Y_RST    = STEP_W'(10);
	localparam logic [THRESH_W-1:0] THRESHOLD_RST = THRESH_W'(3500);

	typedef enum logic [1:0] {
		REG_STEP_X    = 2'd0,
		REG_STEP_Y    = 2'd1,
		REG_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               frame_last;
	} pix_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] delta_sum;
		logic             alert;
	} result_item_t;

	typedef struct packed {
		logic [STEP_W-1:0]   step_x;
		logic [STEP_W-1:0]   step_y;
		logic [THRESH_W-1:0] threshold;
	} cfg_t;

endpackage

[rtl/gfdd_stream_if.sv]
// Valid/ready stream channel carrying one payload item per transaction.
interface gfdd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/gfdd_cfg.sv]
// APB-style configuration registers: sample steps and alert threshold.
module gfdd_cfg
	import gfdd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_x    <= STEP_X_RST;
			cfg_q.step_y    <= STEP_Y_RST;
			cfg_q.threshold <= THRESHOLD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_STEP_X: begin
					cfg_q.step_x <= pwdata[STEP_W-1:0];
				end
				REG_STEP_Y: begin
					cfg_q.step_y <= pwdata[STEP_W-1:0];
				end
				REG_THRESHOLD: begin
					cfg_q.threshold <= pwdata[THRESH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_STEP_X: begin
				prdata = APB_DATA_W'(cfg_q.step_x);
			end
			REG_STEP_Y: begin
				prdata = APB_DATA_W'(cfg_q.step_y);
			end
			REG_THRESHOLD: begin
				prdata = APB_DATA_W'(cfg_q.threshold);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

[rtl/gfdd_grid_map.sv]
// Map a pixel coordinate to its grid cell by matching against step multiples.
module gfdd_grid_map
	import gfdd_pkg::*;
#(
	parameter int GRID_W = GRID_W_DEF,
	parameter int GRID_H = GRID_H_DEF,
	localparam int CELLS = GRID_W * GRID_H,
	localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1
) (
	input  cfg_t               cfg,
	input  logic [COORD_W-1:0] col,
	input  logic [COORD_W-1:0] row,
	output logic               hit,
	output logic [IDX_W-1:0]   idx
);

	localparam int CX_W  = (GRID_W > 1) ? $clog2(GRID_W) : 1;
	localparam int CY_W  = (GRID_H > 1) ? $clog2(GRID_H) : 1;
	localparam int MUL_W = COORD_W + STEP_W;

	logic [STEP_W-1:0] sx;
	logic [STEP_W-1:0] sy;
	logic [MUL_W-1:0]  col_ext;
	logic [MUL_W-1:0]  row_ext;
	logic [MUL_W-1:0]  sx_ext;
	logic [MUL_W-1:0]  sy_ext;
	logic              hit_x;
	logic              hit_y;
	logic [CX_W-1:0]   cx;
	logic [CY_W-1:0]   cy;

	assign sx      = (cfg.step_x == '0) ? STEP_W'(1) : cfg.step_x;
	assign sy      = (cfg.step_y == '0) ? STEP_W'(1) : cfg.step_y;
	assign col_ext = MUL_W'(col);
	assign row_ext = MUL_W'(row);
	assign sx_ext  = MUL_W'(sx);
	assign sy_ext  = MUL_W'(sy);

	always_comb begin
		hit_x = 1'b0;
		cx    = '0;
		for (int x = 0; x < GRID_W; x++) begin
			if (col_ext == MUL_W'(x) * sx_ext) begin
				hit_x = 1'b1;
				cx    = cx | CX_W'(x);
			end
		end
	end

	always_comb begin
		hit_y = 1'b0;
		cy    = '0;
		for (int y = 0; y < GRID_H; y++) begin
			if (row_ext == MUL_W'(y) * sy_ext) begin
				hit_y = 1'b1;
				cy    = cy | CY_W'(y);
			end
		end
	end

	assign hit = hit_x & hit_y;
	assign idx = IDX_W'(cy) * IDX_W'(GRID_W) + IDX_W'(cx);

endmodule

[rtl/gfdd_baseline_mem.sv]
// Baseline pixel store with registered read and a zero-fill sweep after reset.
module gfdd_baseline_mem
	import gfdd_pkg::*;
#(
	parameter int DEPTH = GRID_W_DEF * GRID_H_DEF,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_idx,
	output logic [PIXEL_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_idx,
	input  logic [PIXEL_W-1:0] wr_data,
	output logic               busy
);

	logic [PIXEL_W-1:0] mem_q [DEPTH];
	logic [PIXEL_W-1:0] rd_data_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic               busy_q;
	logic               clr_last;

	assign clr_last = (clr_idx_q == IDX_W'(DEPTH - 1));
	assign busy     = busy_q;
	assign rd_data  = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			if (clr_last) begin
				busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem_q[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

endmodule

[rtl/grid_frame_difference_detector_core.sv]
// Top level of the grid frame difference detector core.
// Accepts one pixel transaction per clock and samples a GRID_W x GRID_H grid at
// multiples of step_x and step_y; each sampled pixel adds its absolute
// difference from the stored baseline of its cell to a saturating 16-bit frame
// sum and becomes the new baseline. The frame_last pixel, on leaving the
// accumulate stage, loads one result transaction (delta_sum, alert = delta_sum >
// threshold), and the sum restarts. Pixels flow through a two-stage pipeline (cell
// lookup and baseline read, then difference and accumulate) at one per cycle.
// Input stalls only while the baseline memory is zero-filled after reset (one
// cell per cycle, GRID_W*GRID_H cells, 192 by default; configuration writes are
// taken as usual) or when a frame result is still waiting on the output and the
// next frame's last pixel reaches the accumulate stage.
`include "grid_frame_difference_detector_core_assert.svh"

module grid_frame_difference_detector_core
	import gfdd_pkg::*;
#(
	parameter int GRID_W = GRID_W_DEF,
	parameter int GRID_H = GRID_H_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	gfdd_stream_if.sink           pixels,
	gfdd_stream_if.source         results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CELLS = GRID_W * GRID_H;
	localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	cfg_t               cfg;
	logic               busy;
	logic               adv;
	logic               frame_end;

	logic               valid_s1;
	pix_item_t          item_s1;
	logic               map_hit;
	logic [IDX_W-1:0]   map_idx;

	logic               valid_s2;
	logic               hit_s2;
	logic               last_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [PIXEL_W-1:0] pixel_s2;
	logic               fwd_s2;
	logic [PIXEL_W-1:0] fwd_pix_s2;
	logic [PIXEL_W-1:0] rd_data;

	logic               wr_en;
	logic [PIXEL_W-1:0] old_pix;
	logic [PIXEL_W-1:0] diff;
	logic [SUM_W:0]     acc;
	logic [SUM_W-1:0]   new_sum;
	logic [SUM_W-1:0]   sum_q;

	logic               out_valid_q;
	result_item_t       out_data_q;

	gfdd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gfdd_grid_map #(
		.GRID_W (GRID_W),
		.GRID_H (GRID_H)
	) u_grid_map (
		.cfg (cfg),
		.col (item_s1.col),
		.row (item_s1.row),
		.hit (map_hit),
		.idx (map_idx)
	);

	gfdd_baseline_mem #(
		.DEPTH (CELLS)
	) u_baseline_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rd_idx  (map_idx),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_idx  (idx_s2),
		.wr_data (pixel_s2),
		.busy    (busy)
	);

	assign adv          = !(valid_s2 && last_s2 && out_valid_q && !results.ready);
	assign pixels.ready = adv && !busy;
	assign wr_en        = adv && valid_s2 && hit_s2;
	assign frame_end    = adv && valid_s2 && last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pixels.valid && pixels.ready;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1    <= pixels.data;
			hit_s2     <= valid_s1 && map_hit;
			last_s2    <= item_s1.frame_last;
			idx_s2     <= map_idx;
			pixel_s2   <= item_s1.pixel;
			fwd_s2     <= wr_en && valid_s1 && map_hit && (idx_s2 == map_idx);
			fwd_pix_s2 <= pixel_s2;
		end
	end

	assign old_pix = fwd_s2 ? fwd_pix_s2 : rd_data;
	assign diff    = (pixel_s2 >= old_pix) ? (pixel_s2 - old_pix) : (old_pix - pixel_s2);
	assign acc     = {1'b0, sum_q} + (SUM_W + 1)'(diff);
	assign new_sum = !hit_s2 ? sum_q : (acc[SUM_W] ? '1 : acc[SUM_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && valid_s2) begin
				sum_q <= last_s2 ? '0 : new_sum;
			end
			if (frame_end) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_end) begin
			out_data_q.delta_sum <= new_sum;
			out_data_q.alert     <= (new_sum > cfg.threshold);
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

	`GFDD_ASSERT_NOW(a_no_accept_in_clear, busy, !pixels.ready, "accept during clear")
	`GFDD_ASSERT_NEXT(a_result_loaded, frame_end, out_valid_q && (sum_q == '0), "result not loaded")
	`GFDD_ASSERT_NOW(a_fwd_on_hit, valid_s2 && fwd_s2, hit_s2, "forward on off-grid pixel")
	`GFDD_ASSERT_NEXT(a_stall_holds_stage, !adv, valid_s2 && last_s2 && $stable(sum_q), "stall moved")

endmodule

[dv/grid_frame_difference_detector_core_test.sv]
// Self-checking testbench for the grid frame difference detector core.
`timescale 1ns / 1ps

module grid_frame_difference_detector_core_test;
	import gfdd_pkg::*;

	localparam int CELLS = GRID_W_DEF * GRID_H_DEF;
	localparam int COORD_TOP = (1 << COORD_W) - 1;
	localparam int PHASES = 8;
	localparam int PHASE_QUOTA = 80;
	localparam int SAT_RUN = 300;

	class frame_sum_board;
		logic [PIXEL_W-1:0] cell_base [CELLS];
		logic [SUM_W-1:0]   frame_sum;
		cfg_t               regs;
		result_item_t       pending_sums[$];
		int                 mismatches;
		int                 pixels_taken;
		int                 grid_hits;
		int                 frames_done;
		int                 alerts_seen;
		int                 saturated;

		function new();
			foreach (cell_base[i]) cell_base[i] = '0;
			frame_sum = '0;
			regs.step_x = STEP_X_RST;
			regs.step_y = STEP_Y_RST;
			regs.threshold = THRESHOLD_RST;
			mismatches = 0;
			pixels_taken = 0;
			grid_hits = 0;
			frames_done = 0;
			alerts_seen = 0;
			saturated = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
			case (idx)
				REG_STEP_X: regs.step_x = val[STEP_W-1:0];
				REG_STEP_Y: regs.step_y = val[STEP_W-1:0];
				REG_THRESHOLD: regs.threshold = val[THRESH_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_pixel(pix_item_t px);
			int unsigned sx;
			int unsigned sy;
			int unsigned cx;
			int unsigned cy;
			int unsigned idx;
			int unsigned diff;
			int unsigned acc;
			result_item_t want;
			sx = (regs.step_x == 0) ? 1 : regs.step_x;
			sy = (regs.step_y == 0) ? 1 : regs.step_y;
			pixels_taken++;
			if ((px.col % sx) == 0 && (px.row % sy) == 0) begin
				cx = px.col / sx;
				cy = px.row / sy;
				if (cx < GRID_W_DEF && cy < GRID_H_DEF) begin
					idx = cy * GRID_W_DEF + cx;
					diff = (px.pixel >= cell_base[idx]) ? px.pixel - cell_base[idx] :
						cell_base[idx] - px.pixel;
					acc = frame_sum + diff;
					frame_sum = (acc > {SUM_W{1'b1}}) ? {SUM_W{1'b1}} : SUM_W'(acc);
					cell_base[idx] = px.pixel;
					grid_hits++;
				end
			end
			if (px.frame_last) begin
				want.delta_sum = frame_sum;
				want.alert = frame_sum > regs.threshold;
				pending_sums.push_back(want);
				frame_sum = '0;
			end
		endfunction

		function void check_result(result_item_t got);
			result_item_t want;
			if (pending_sums.size() == 0) begin
				$error("unexpected result: delta_sum %0d alert %0d", got.delta_sum, got.alert);
				mismatches++;
				return;
			end
			want = pending_sums.pop_front();
			frames_done++;
			if (got.alert === 1'b1) alerts_seen++;
			if (got.delta_sum === {SUM_W{1'b1}}) saturated++;
			if (got.delta_sum !== want.delta_sum) begin
				$error("delta_sum: expected %0d, actual %0d", want.delta_sum, got.delta_sum);
				mismatches++;
			end
			if (got.alert !== want.alert) begin
				$error("alert: expected %0d, actual %0d", want.alert, got.alert);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	gfdd_stream_if #(.T(pix_item_t)) pix_ch ();
	gfdd_stream_if #(.T(result_item_t)) res_ch ();

	frame_sum_board board;
	bit src_steady;
	bit snk_steady;
	int grid_sent;

	grid_frame_difference_detector_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix_ch),
		.results(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	function automatic int unsigned top_cell(int unsigned step, int unsigned cells);
		return (COORD_TOP / step < cells - 1) ? COORD_TOP / step : cells - 1;
	endfunction

	function automatic logic [PIXEL_W-1:0] pick_pixel();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return PIXEL_W'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic [COORD_W-1:0] col,
			input logic [COORD_W-1:0] row, input logic frame_last);
		pix_item_t px;
		int unsigned gap;
		px.pixel = pixel;
		px.col = col;
		px.row = row;
		px.frame_last = frame_last;
		gap = src_steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.data <= px;
		@(negedge clk);
		while (pix_ch.ready !== 1'b1) @(negedge clk);
		@(posedge clk);
		board.note_pixel(px);
	endtask

	task automatic wait_drained();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_sums.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_frame(input int unsigned sx, input int unsigned sy,
			input int unsigned len);
		int unsigned cx_top;
		int unsigned cy_top;
		int unsigned cx;
		int unsigned cy;
		int unsigned n;
		int unsigned kind;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		cx_top = top_cell(sx, GRID_W_DEF);
		cy_top = top_cell(sy, GRID_H_DEF);
		cx = $urandom_range(0, cx_top);
		cy = $urandom_range(0, cy_top);
		for (n = 0; n < len; n++) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				col = COORD_W'($urandom);
				row = COORD_W'($urandom);
			end else begin
				if (kind > 3) begin
					cx = $urandom_range(0, cx_top);
					cy = $urandom_range(0, cy_top);
				end
				col = COORD_W'(cx * sx);
				row = COORD_W'(cy * sy);
				grid_sent++;
			end
			send_pixel(pick_pixel(), col, row, n == len - 1);
		end
	endtask

	task automatic send_sweep(input int unsigned sx, input int unsigned sy);
		int unsigned cx_top;
		int unsigned cy_top;
		int unsigned cx;
		int unsigned cy;
		cx_top = top_cell(sx, GRID_W_DEF);
		cy_top = top_cell(sy, GRID_H_DEF);
		for (cy = 0; cy <= cy_top; cy++) begin
			for (cx = 0; cx <= cx_top; cx++) begin
				send_pixel(pick_pixel(), COORD_W'(cx * sx), COORD_W'(cy * sy),
					cx == cx_top && cy == cy_top);
				grid_sent++;
			end
		end
	endtask

	initial begin : result_sink
		int unsigned stall;
		result_item_t got;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = snk_steady ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(negedge clk);
			while (res_ch.valid !== 1'b1) @(negedge clk);
			got = res_ch.data;
			@(posedge clk);
			board.check_result(got);
		end
	end

	initial begin : stimulus
		int unsigned ph;
		int unsigned i;
		int unsigned sx_raw;
		int unsigned sy_raw;
		int unsigned th;
		int unsigned sx;
		int unsigned sy;
		int phase_goal;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_ch.valid = 1'b0;
		pix_ch.data = '0;
		src_steady = 1'b0;
		snk_steady = 1'b0;
		grid_sent = 0;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(8'd255, 10'd0, 10'd0, 1'b0);
		send_pixel(8'd0, 10'd150, 10'd110, 1'b0);
		send_pixel(8'd200, 10'd150, 10'd110, 1'b0);
		send_pixel(8'd0, 10'd150, 10'd110, 1'b0);
		send_pixel(8'd255, 10'd5, 10'd0, 1'b0);
		send_pixel(8'd255, 10'd160, 10'd0, 1'b0);
		send_pixel(8'd255, 10'd0, 10'd120, 1'b0);
		send_pixel(8'd255, 10'd1023, 10'd1023, 1'b0);
		send_pixel(8'd128, 10'd10, 10'd10, 1'b1);
		send_pixel(8'd0, 10'd1023, 10'd1023, 1'b1);
		for (i = 0; i < 14; i++) send_pixel(8'd255, COORD_W'(i * 10), 10'd20, 1'b0);
		send_pixel(8'd255, 10'd140, 10'd20, 1'b1);

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin sx_raw = 1; sy_raw = 1; th = 0; end
				1: begin sx_raw = 64; sy_raw = 85; th = 65535; end
				2: begin sx_raw = 0; sy_raw = 0; th = $urandom_range(0, 4000); end
				3: begin sx_raw = 127; sy_raw = 127; th = $urandom_range(0, 4000); end
				default: begin
					sx_raw = $urandom_range(1, 64);
					sy_raw = $urandom_range(1, 85);
					th = $urandom_range(0, 6000);
				end
			endcase
			wait_drained();
			write_reg(REG_STEP_X, sx_raw);
			write_reg(REG_STEP_Y, sy_raw);
			write_reg(REG_THRESHOLD, th);
			src_steady = (ph % 4 == 1) || (ph % 4 == 2);
			snk_steady = (ph % 4 == 1);
			sx = (sx_raw == 0) ? 1 : sx_raw;
			sy = (sy_raw == 0) ? 1 : sy_raw;

			if (ph == 1) begin
				for (i = 0; i < SAT_RUN; i++) begin
					send_pixel(i[0] ? 8'd255 : 8'd0, COORD_W'(top_cell(sx, GRID_W_DEF) * sx),
						COORD_W'(top_cell(sy, GRID_H_DEF) * sy), i == SAT_RUN - 1);
				end
			end

			phase_goal = grid_sent + PHASE_QUOTA;
			while (grid_sent < phase_goal) begin
				if ($urandom_range(0, 9) == 0) send_sweep(sx, sy);
				else send_frame(sx, sy, $urandom_range(1, 30));
				if ($urandom_range(0, 15) == 0) wait_drained();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Run covered %0d pixel transactions, %0d on the grid, over %0d register settings",
			board.pixels_taken, board.grid_hits, PHASES + 1);
		$display("Checked %0d frame results: %0d with alert, %0d saturated",
			board.frames_done, board.alerts_seen, board.saturated);
		if (board.mismatches == 0 && board.pending_sums.size() == 0) begin
			$display("PASS grid_frame_difference_detector_core");
		end else begin
			$display("FAIL grid_frame_difference_detector_core");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("FAIL grid_frame_difference_detector_core");
		$finish;
	end

endmodule
